@@ rtl/spds_pkg.sv @@
// ----------------------------------------------------------------------------
// spds_pkg
// shared types and constants for the servo pulse decoder with slewing shaft
// ----------------------------------------------------------------------------
package spds_pkg;

  localparam int unsigned AngleW   = 8;
  localparam int unsigned WidthW   = 16;
  localparam int unsigned RateW    = 16;

  localparam logic [AngleW-1:0] CenterDeg  = 8'd90;
  localparam logic [AngleW-1:0] MaxDeg     = 8'd180;
  localparam logic [WidthW-1:0] MinPulseUs = 16'd1000;
  localparam logic [WidthW-1:0] MaxPulseUs = 16'd2000;
  localparam logic [WidthW-1:0] WidthMax   = 16'hFFFF;
  localparam logic [RateW-1:0]  RateReset  = 16'd3333;

  // floor(d * 180 / 1000) == (d * RecipDeg) >> RecipShift for d in 0..1000
  localparam int unsigned       RecipShift = 20;
  localparam logic [17:0]       RecipDeg   = 18'd188748;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  // what the front decided about one tick
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CENTER = 2'd1,
    EV_SET    = 2'd2
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e          kind;
    logic [AngleW-1:0] angle;
  } ev_t;

  // queue handshake status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/spds_front.sv @@
// ----------------------------------------------------------------------------
// spds_front
// edge detection, pulse width measurement and width-to-angle mapping
// ----------------------------------------------------------------------------
module spds_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic           sig_level_i,
  input  logic           power_ok_i,
  output spds_pkg::ev_t  ev_o
);

  logic                          prev_sig_q, prev_sig_d;
  logic                          armed_q, armed_d;
  logic [spds_pkg::WidthW-1:0]   width_q, width_d;
  logic [spds_pkg::WidthW-1:0]   width_inc;
  logic [spds_pkg::WidthW-1:0]   diff;
  logic [27:0]                   prod;
  logic [spds_pkg::AngleW-1:0]   angle;
  logic                          rising, falling;

  assign rising  = sig_level_i & ~prev_sig_q;
  assign falling = ~sig_level_i & prev_sig_q;

  assign width_inc = (width_q == spds_pkg::WidthMax) ? width_q : width_q + 16'd1;

  // only 1..999 reaches the product, the rest is clamped
  assign diff = width_inc - spds_pkg::MinPulseUs;
  assign prod = 28'(diff[9:0]) * 28'(spds_pkg::RecipDeg);

  always_comb begin
    if (width_inc <= spds_pkg::MinPulseUs) begin
      angle = '0;
    end else if (width_inc >= spds_pkg::MaxPulseUs) begin
      angle = spds_pkg::MaxDeg;
    end else begin
      angle = prod[spds_pkg::RecipShift +: spds_pkg::AngleW];
    end
  end

  always_comb begin
    prev_sig_d = prev_sig_q;
    armed_d    = armed_q;
    width_d    = width_q;
    ev_o.kind  = spds_pkg::EV_NONE;
    ev_o.angle = angle;
    if (!power_ok_i) begin
      ev_o.kind  = spds_pkg::EV_CENTER;
      ev_o.angle = spds_pkg::CenterDeg;
      armed_d    = 1'b0;
      width_d    = '0;
    end else if (rising) begin
      armed_d = 1'b1;
      width_d = '0;
    end else if (armed_q) begin
      if (falling) begin
        ev_o.kind = spds_pkg::EV_SET;
        armed_d   = 1'b0;
        width_d   = '0;
      end else begin
        width_d = width_inc;
      end
    end
    if (take_i) begin
      prev_sig_d = sig_level_i;
    end else begin
      armed_d = armed_q;
      width_d = width_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sig_q <= 1'b0;
      armed_q    <= 1'b0;
      width_q    <= '0;
    end else begin
      prev_sig_q <= prev_sig_d;
      armed_q    <= armed_d;
      width_q    <= width_d;
    end
  end

endmodule

@@ rtl/spds_queue.sv @@
// ----------------------------------------------------------------------------
// spds_queue
// two-entry register queue between the front and the back
// ----------------------------------------------------------------------------
module spds_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  spds_pkg::ev_t     push_data_i,
  input  logic              pop_i,
  output spds_pkg::ev_t     pop_data_o,
  output spds_pkg::q_stat_t stat_o
);

  spds_pkg::ev_t  entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/spds_back.sv @@
// ----------------------------------------------------------------------------
// spds_back
// target update, shaft slewing and the output register
// ----------------------------------------------------------------------------
module spds_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [spds_pkg::RateW-1:0]    us_per_degree_i,
  input  spds_pkg::ev_t                 ev_i,
  input  logic                          ev_valid_i,
  output logic                          ev_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [spds_pkg::AngleW-1:0]   position_o,
  output logic [spds_pkg::AngleW-1:0]   target_angle_o,
  output logic                          moving_o
);

  logic [spds_pkg::AngleW-1:0] target_q, target_d;
  logic [spds_pkg::AngleW-1:0] angle_q, angle_d;
  logic [spds_pkg::RateW-1:0]  slew_q, slew_d;
  logic [spds_pkg::RateW:0]    slew_next;
  logic                        valid_q, valid_d;

  assign ev_pop_o  = ev_valid_i & (~valid_q | out_ready_i);
  assign slew_next = {1'b0, slew_q} + 17'd1;

  always_comb begin
    target_d = target_q;
    angle_d  = angle_q;
    slew_d   = slew_q;
    valid_d  = valid_q & ~out_ready_i;
    if (ev_pop_o) begin
      valid_d = 1'b1;
      if (ev_i.kind != spds_pkg::EV_NONE) begin
        target_d = ev_i.angle;
      end
      if (angle_q != target_d) begin
        // rate of zero behaves like one since the compare always passes
        if (slew_next >= {1'b0, us_per_degree_i}) begin
          slew_d  = '0;
          angle_d = (angle_q < target_d) ? angle_q + 8'd1 : angle_q - 8'd1;
        end else begin
          slew_d = slew_next[spds_pkg::RateW-1:0];
        end
      end else begin
        slew_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= spds_pkg::CenterDeg;
      angle_q  <= spds_pkg::CenterDeg;
      slew_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      target_q <= target_d;
      angle_q  <= angle_d;
      slew_q   <= slew_d;
      valid_q  <= valid_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign position_o     = angle_q;
  assign target_angle_o = target_q;
  assign moving_o       = (angle_q != target_q);

endmodule

@@ rtl/servo_pulse_decode_slew_unit.sv @@
// ----------------------------------------------------------------------------
// servo_pulse_decode_slew_unit
// rc servo pulse width decoder driving a shaft that slews at a set rate
// ----------------------------------------------------------------------------
// usage:
//   each input item is one 1 us tick: tdata[0] is the control line level,
//   tdata[1] the power-present level. every item gives exactly one output
//   item with the shaft position, the commanded target and a moving flag.
//   a rising edge arms the width counter, the next falling edge turns the
//   pulse width into a target of (width-1000)*180/1000 degrees, clamped to
//   0..180. without power the target returns to 90 and any measurement is
//   dropped. the shaft moves one degree every us_per_degree ticks.
//   cfg_we_i/cfg_wdata_i write us_per_degree (reset 3333), only while idle.
// timing:
//   one item per cycle while the output is not stalled; an accepted item is
//   written into the queue, popped from there into the output register once
//   that register is free, and leaves when m_axis_tready is high.
// reset and stall:
//   reset centers shaft and target at 90 degrees and clears the queue. when
//   the receiver stalls the output register holds, the two-entry queue
//   fills, and then s_axis_tready drops until space frees up.
// ----------------------------------------------------------------------------
module servo_pulse_decode_slew_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: us_per_degree
  input  logic                              cfg_we_i,
  input  logic [spds_pkg::RateW-1:0]        cfg_wdata_i,
  // input ticks
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [spds_pkg::InDataW-1:0]      s_axis_tdata,   // sig_level, power_ok, pad
  // results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [spds_pkg::OutDataW-1:0]     m_axis_tdata    // position, target_angle, moving, pad
);

  logic [spds_pkg::RateW-1:0]  rate_q;
  spds_pkg::ev_t               front_ev;
  spds_pkg::ev_t               back_ev;
  spds_pkg::q_stat_t           q_stat;
  logic                        take;
  logic                        pop;
  logic [spds_pkg::AngleW-1:0] position;
  logic [spds_pkg::AngleW-1:0] target_angle;
  logic                        moving;

  // slew rate register, to be written only while the block is idle; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= spds_pkg::RateReset;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  // an item is taken whenever the queue has room
  assign s_axis_tready = ~q_stat.full;
  assign take          = s_axis_tvalid & s_axis_tready;

  spds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .sig_level_i (s_axis_tdata[0]),
    .power_ok_i  (s_axis_tdata[1]),
    .ev_o        (front_ev)
  );

  spds_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .push_data_i (front_ev),
    .pop_i       (pop),
    .pop_data_o  (back_ev),
    .stat_o      (q_stat)
  );

  spds_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .us_per_degree_i (rate_q),
    .ev_i            (back_ev),
    .ev_valid_i      (~q_stat.empty),
    .ev_pop_o        (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .position_o      (position),
    .target_angle_o  (target_angle),
    .moving_o        (moving)
  );

  // pack results, lowest field first, padded to whole bytes
  assign m_axis_tdata = {7'd0, moving, target_angle, position};

endmodule

@@ sim/servo_pulse_decode_slew_unit_tb.sv @@
// ----------------------------------------------------------------------------
// servo_pulse_decode_slew_unit_tb
// self-checking bench for the servo pulse decoder with slewing shaft
// ----------------------------------------------------------------------------
// every tick sent into the unit is run through a local shaft model at the
// moment it is accepted, and the predicted position, target and moving flag
// are queued. each output item is checked field by field against the oldest
// queued prediction. directed tests hit the edge cases of the pulse decoder,
// random tests push short pulses mixed with noise and power dropouts
// under three source/sink idling profiles.
// ----------------------------------------------------------------------------
module servo_pulse_decode_slew_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SpanUs      = 1000;  // pulse span from 0 to 180 degrees
  localparam int unsigned NoDrop      = 32'hFFFF_FFFF;
  localparam int unsigned DrainCycles = 8;     // settling time after the last predicted item is out
  localparam int unsigned QuietLimit  = 4000;  // cycles with no item moving at all
  localparam int unsigned RandBudget  = 110;   // ticks per random phase

  // one observed or predicted output item
  typedef struct packed {
    logic [spds_pkg::AngleW-1:0] position;
    logic [spds_pkg::AngleW-1:0] target;
    logic                        moving;
  } shaft_obs_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [spds_pkg::RateW-1:0]    cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [spds_pkg::InDataW-1:0]  s_axis_tdata;   // sig_level, power_ok, pad
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [spds_pkg::OutDataW-1:0] m_axis_tdata;   // position, target_angle, moving, pad

  // shaft model state
  logic                        line_prev;
  logic                        width_armed;
  logic [spds_pkg::WidthW-1:0] pulse_width;
  logic [spds_pkg::AngleW-1:0] cmd_angle;
  logic [spds_pkg::AngleW-1:0] shaft_angle;
  logic [spds_pkg::RateW-1:0]  slew_ticks;
  logic [spds_pkg::RateW-1:0]  slew_rate;

  shaft_obs_t  shaft_expect_q[$];
  int unsigned err_count;
  int unsigned ticks_sent;
  int unsigned quiet_cycles;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  servo_pulse_decode_slew_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver backpressure, one decision per cycle
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // shaft model
  // --------------------------------------------------------------------------

  // pulse width in microseconds to commanded angle, truncating, clamped
  function automatic logic [spds_pkg::AngleW-1:0] width_to_deg(
    input logic [spds_pkg::WidthW-1:0] w
  );
    int unsigned deg;
    if (w <= spds_pkg::MinPulseUs) return '0;
    deg = (32'(w) - 32'(spds_pkg::MinPulseUs)) * 32'(spds_pkg::MaxDeg) / SpanUs;
    if (deg > 32'(spds_pkg::MaxDeg)) deg = 32'(spds_pkg::MaxDeg);
    return deg[spds_pkg::AngleW-1:0];
  endfunction

  // advance the shaft model by one tick and return what the unit should show
  function automatic shaft_obs_t shaft_step(input logic sig, input logic pwr);
    int unsigned nxt;
    shaft_obs_t  res;
    // edge and power handling
    if (!pwr) begin
      cmd_angle   = spds_pkg::CenterDeg;
      width_armed = 1'b0;
      pulse_width = '0;
    end else if (sig && !line_prev) begin
      width_armed = 1'b1;
      pulse_width = '0;
    end else if (width_armed) begin
      if (pulse_width != spds_pkg::WidthMax) pulse_width = pulse_width + 16'd1;
      if (!sig && line_prev) begin
        cmd_angle   = width_to_deg(pulse_width);
        width_armed = 1'b0;
        pulse_width = '0;
      end
    end
    line_prev = sig;
    // slew toward the possibly new target; a rate of zero behaves like one
    if (shaft_angle != cmd_angle) begin
      nxt = 32'(slew_ticks) + 1;
      if (nxt >= 32'(slew_rate)) begin
        slew_ticks = '0;
        if (shaft_angle < cmd_angle) shaft_angle = shaft_angle + 8'd1;
        else shaft_angle = shaft_angle - 8'd1;
      end else begin
        slew_ticks = nxt[spds_pkg::RateW-1:0];
      end
    end else begin
      slew_ticks = '0;
    end
    res.position = shaft_angle;
    res.target   = cmd_angle;
    res.moving   = (shaft_angle != cmd_angle);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // result checker: compare outputs, predict on every accepted input item
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    shaft_obs_t got;
    shaft_obs_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.position = m_axis_tdata[spds_pkg::AngleW-1:0];
        got.target   = m_axis_tdata[2*spds_pkg::AngleW-1:spds_pkg::AngleW];
        got.moving   = m_axis_tdata[2*spds_pkg::AngleW];
        if (shaft_expect_q.size() == 0) begin
          $display("%0t: unexpected item, expected none actual %h", $time, got);
          err_count++;
        end else begin
          want = shaft_expect_q.pop_front();
          if (got.position !== want.position) begin
            $display("%0t: position mismatch, expected %0d actual %0d",
                     $time, want.position, got.position);
            err_count++;
          end
          if (got.target !== want.target) begin
            $display("%0t: target_angle mismatch, expected %0d actual %0d",
                     $time, want.target, got.target);
            err_count++;
          end
          if (got.moving !== want.moving) begin
            $display("%0t: moving mismatch, expected %0b actual %0b",
                     $time, want.moving, got.moving);
            err_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        shaft_expect_q.push_back(shaft_step(s_axis_tdata[0], s_axis_tdata[1]));
    end
    // watchdog bookkeeping
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  // ends the run if nothing moves for too long
  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("%0t: timeout with %0d items outstanding", $time, shaft_expect_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // send one tick, with random source gaps, and wait until it is taken
  task automatic send_tick(input logic sig, input logic pwr);
    while (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(spds_pkg::InDataW-2){1'b0}}, pwr, sig};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ticks_sent++;
  endtask

  // line low for gap ticks, high for width ticks, then one falling tick;
  // power drops on high tick drop_at if that is inside the pulse
  task automatic send_pulse(input int unsigned gap, input int unsigned width,
                            input int unsigned drop_at);
    for (int unsigned i = 0; i < gap; i++) send_tick(1'b0, 1'b1);
    for (int unsigned i = 0; i < width; i++) send_tick(1'b1, i != drop_at);
    send_tick(1'b0, 1'b1);
  endtask

  // stop sending and wait for every predicted item to come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (shaft_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // us_per_degree write, only with the unit idle
  task automatic write_rate(input logic [spds_pkg::RateW-1:0] rate);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    slew_rate = rate;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // out of reset the shaft sits centered at the default rate
  task automatic test_center_hold();
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
  endtask

  // zero rate moves a degree per tick; a one-tick pulse commands zero
  task automatic test_zero_rate_short_pulse();
    write_rate('0);
    send_pulse(1, 1, NoDrop);
    repeat (3) send_tick(1'b0, 1'b1);
  endtask

  // falling edge without arming is ignored; losing power recenters and
  // drops a pulse in progress
  task automatic test_unarmed_fall_and_power_loss();
    write_rate(16'd1);
    send_tick(1'b1, 1'b0);   // rise hidden by missing power
    send_tick(1'b1, 1'b1);   // no edge, still unarmed
    send_tick(1'b0, 1'b1);   // unarmed fall
    send_pulse(0, 4, 2);     // power lost mid pulse
    send_tick(1'b0, 1'b1);
  endtask

  // a rate lowered below the running count steps the shaft at once
  task automatic test_rate_lowered();
    write_rate(16'hFFFF);
    send_pulse(1, 2, NoDrop);
    repeat (30) send_tick(1'b0, 1'b1);
    write_rate(16'd8);
    repeat (4) send_tick(1'b0, 1'b1);
  endtask

  // a pulse around the low end of the servo range goes through the scaling
  task automatic test_long_pulse();
    write_rate(16'd1);
    send_pulse(3, $urandom_range(1060, 995), NoDrop);
    repeat (4) send_tick(1'b0, 1'b1);
  endtask

  // short pulses, noise, dropouts and broken pulses
  task automatic test_random_pulses(input logic [spds_pkg::RateW-1:0] rate);
    int unsigned start;
    int unsigned kind;
    int unsigned w;
    bit          paused;
    write_rate(rate);
    start  = ticks_sent;
    paused = 1'b0;
    while (ticks_sent - start < RandBudget) begin
      // sender holds off once until the unit has caught up
      if (!paused && ticks_sent - start >= RandBudget / 2) begin
        drain_results();
        paused = 1'b1;
      end
      kind = $urandom_range(9, 0);
      if (kind == 0) begin
        repeat ($urandom_range(8, 1)) send_tick(1'($urandom), 1'($urandom));
      end else if (kind == 1) begin
        repeat ($urandom_range(5, 1)) send_tick(1'($urandom), 1'b0);
      end else begin
        w = $urandom_range(40, 1);
        send_pulse($urandom_range(5, 1), w,
                   ($urandom_range(3, 0) == 0) ? $urandom_range(w - 1, 0) : NoDrop);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    err_count    = 0;
    ticks_sent   = 0;
    quiet_cycles = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    // model reset: centered, disarmed, default rate
    line_prev   = 1'b0;
    width_armed = 1'b0;
    pulse_width = '0;
    cmd_angle   = spds_pkg::CenterDeg;
    shaft_angle = spds_pkg::CenterDeg;
    slew_ticks  = '0;
    slew_rate   = spds_pkg::RateReset;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // light source gaps, heavy sink stalls
    src_idle_pct = 8;
    snk_idle_pct = 56;
    test_center_hold();
    test_zero_rate_short_pulse();
    test_unarmed_fall_and_power_loss();
    test_rate_lowered();
    test_random_pulses(16'd3);

    // heavy source gaps, light sink stalls
    src_idle_pct = 56;
    snk_idle_pct = 8;
    test_random_pulses(16'd17);

    // full rate both ways
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_long_pulse();
    test_random_pulses(16'd1);

    drain_results();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
